### sv/srma_pkg.sv
// ----------------------------------------------------------------------------
// srma_pkg
// Shared types, widths, codes and reset values of the sensor running-average
// monitor.
// ----------------------------------------------------------------------------
package srma_pkg;

	localparam int WINDOW_LEN_DEF  = 5;
	localparam int MAX_SENSORS_DEF = 64;

	localparam int TEMP_W    = 16;
	localparam int ID_W      = 16;
	localparam int TIME_W    = 32;
	localparam int CODE_W    = 3;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = 2'd1;

	localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 16'sd4608;
	localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 16'sd5632;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [CODE_W-1:0] EV_OK        = 3'd0;
	localparam logic [CODE_W-1:0] EV_TOO_COLD  = 3'd1;
	localparam logic [CODE_W-1:0] EV_TOO_WARM  = 3'd2;
	localparam logic [CODE_W-1:0] EV_UNKNOWN   = 3'd3;
	localparam logic [CODE_W-1:0] EV_DUPLICATE = 3'd4;
	localparam logic [CODE_W-1:0] EV_FULL      = 3'd5;

	typedef struct packed {
		logic                     mode;
		logic [ID_W-1:0]          sensor_tag;
		logic [ID_W-1:0]          room_id;
		logic signed [TEMP_W-1:0] sample_value;
		logic [TIME_W-1:0]        sample_time;
	} in_item_t;

	typedef struct packed {
		logic [CODE_W-1:0]        event_code;
		logic [ID_W-1:0]          event_sensor;
		logic [ID_W-1:0]          event_room;
		logic signed [TEMP_W-1:0] average;
		logic [TIME_W-1:0]        event_time;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WREAD,
		ST_MUL,
		ST_DONE
	} seq_state_t;

endpackage

### sv/srma_stream_if.sv
// ----------------------------------------------------------------------------
// srma_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface srma_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### sv/srma_ram.sv
// ----------------------------------------------------------------------------
// srma_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/sensor_running_average_monitor.sv
// ----------------------------------------------------------------------------
// sensor_running_average_monitor
// Sensor table with per-sensor sample windows, window average and
// temperature limit alarms.
// ----------------------------------------------------------------------------
// Usage:
//  req  : input beats. mode 0 loads a sensor-to-room entry, mode 1 reports
//         a sample. rsp : exactly one event beat per request beat.
//  cfg  : cfg_we/cfg_idx/cfg_wdata write min_temp (0) and max_temp (1);
//         other indexes are dropped. Write only while the block is idle.
// Flow: one beat at a time. req.ready is high only while idle. A load or
//  an unknown sample steps through IDLE, SEARCH and DONE; a known sample
//  through IDLE, SEARCH, WREAD, MUL and DONE. SEARCH scans the map RAM
//  linearly, one entry per cycle, up to the hit or over all entries on a
//  miss; an empty table skips SEARCH. DONE waits for the output register.
// Reset: entry count cleared, limits return to 18.0 and 22.0 degrees. RAMs
//  are not cleared; a window is zeroed when its entry is loaded.
// Stall: the event sits in an output register; the next request beat is
//  accepted meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module sensor_running_average_monitor #(
	parameter int WINDOW_LEN  = srma_pkg::WINDOW_LEN_DEF,
	parameter int MAX_SENSORS = srma_pkg::MAX_SENSORS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	srma_stream_if.sink                     req,
	srma_stream_if.source                   rsp,
	input  logic                            cfg_we,
	input  logic [srma_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srma_pkg::CFG_W-1:0]      cfg_wdata
);
	import srma_pkg::*;

	localparam int IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int CNT_W   = $clog2(MAX_SENSORS + 1);
	localparam int WIN_W   = TEMP_W * WINDOW_LEN;
	localparam int MAP_W   = 2 * ID_W;
	localparam int SUM_W   = TEMP_W + $clog2(WINDOW_LEN);
	localparam int RECIP_K = SUM_W + $clog2(WINDOW_LEN);
	localparam int PROD_W  = SUM_W + RECIP_K;
	localparam logic [RECIP_K-1:0] RECIP =
		RECIP_K'(((64'd1 << RECIP_K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	seq_state_t state_q, state_d;

	logic signed [TEMP_W-1:0] min_temp_q, max_temp_q;
	logic [CNT_W-1:0]         entry_count_q;
	in_item_t                 item_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic                     found_q;
	logic [ID_W-1:0]          room_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     oldest_nz_q;
	logic                     sign_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     rsp_valid_q;
	out_item_t                rsp_data_q;

	logic                     map_we, win_we;
	logic [IDX_W-1:0]         map_raddr, win_waddr, new_idx;
	logic [MAP_W-1:0]         map_rdata;
	logic [WIN_W-1:0]         win_rdata, win_wdata, win_shift;
	logic                     hit, last, full, out_free, do_insert;
	logic [ID_W-1:0]          hit_room;
	logic signed [SUM_W-1:0]  win_sum;
	logic [SUM_W-1:0]         abs_sum;
	logic [TEMP_W:0]          quot;
	logic signed [TEMP_W-1:0] avg;
	out_item_t                res;

	assign hit      = (map_rdata[MAP_W-1 -: ID_W] == item_q.sensor_tag);
	assign hit_room = map_rdata[ID_W-1:0];
	assign last     = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == entry_count_q);
	assign full     = (entry_count_q == CNT_W'(MAX_SENSORS));
	assign out_free = !rsp_valid_q || rsp.ready;
	assign new_idx  = IDX_W'(entry_count_q);
	assign do_insert = (state_q == ST_DONE) && out_free && (item_q.mode == MODE_LOAD)
		&& !found_q && !full;

	assign map_raddr = (state_q == ST_SEARCH) ? rd_idx_q + IDX_W'(1) : '0;
	assign map_we    = do_insert;
	assign win_we    = do_insert || (state_q == ST_WREAD);
	assign win_waddr = (state_q == ST_WREAD) ? rd_idx_q : new_idx;
	assign win_wdata = (state_q == ST_WREAD) ? win_shift : '0;

	srma_ram #(.WIDTH(MAP_W), .DEPTH(MAX_SENSORS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (new_idx),
		.wdata ({item_q.sensor_tag, item_q.room_id}),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	srma_ram #(.WIDTH(WIN_W), .DEPTH(MAX_SENSORS)) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_waddr),
		.wdata (win_wdata),
		.raddr (rd_idx_q),
		.rdata (win_rdata)
	);

	// slot 0 is the oldest sample
	always_comb begin
		win_shift = {item_q.sample_value, win_rdata[WIN_W-1:TEMP_W]};
		win_sum   = '0;
		for (int k = 0; k < WINDOW_LEN; k++) begin
			win_sum = win_sum + SUM_W'(signed'(win_shift[k*TEMP_W +: TEMP_W]));
		end
	end

	assign abs_sum = sum_q[SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
	assign quot    = prod_q[RECIP_K +: TEMP_W+1];

	always_comb begin
		avg = '0;
		if (oldest_nz_q) begin
			avg = sign_q ? signed'(TEMP_W'(-quot)) : signed'(TEMP_W'(quot));
		end
	end

	always_comb begin
		res.event_sensor = item_q.sensor_tag;
		res.event_room   = item_q.room_id;
		res.average      = '0;
		res.event_time   = '0;
		res.event_code   = EV_OK;
		if (item_q.mode == MODE_LOAD) begin
			if (found_q) begin
				res.event_code = EV_DUPLICATE;
				res.event_room = room_q;
			end else if (full) begin
				res.event_code = EV_FULL;
			end
		end else begin
			res.event_time = item_q.sample_time;
			if (!found_q) begin
				res.event_code = EV_UNKNOWN;
				res.event_room = '0;
			end else begin
				res.event_room = room_q;
				res.average    = avg;
				if (avg != 0 && avg < min_temp_q) begin
					res.event_code = EV_TOO_COLD;
				end else if (avg != 0 && avg > max_temp_q) begin
					res.event_code = EV_TOO_WARM;
				end
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (entry_count_q == '0) ? ST_DONE : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = (item_q.mode == MODE_SAMPLE) ? ST_WREAD : ST_DONE;
				end else if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_WREAD: state_d = ST_MUL;
			ST_MUL:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q    <= MIN_TEMP_RST;
			max_temp_q    <= MAX_TEMP_RST;
			entry_count_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_MIN_TEMP: min_temp_q <= signed'(cfg_wdata);
					REG_MAX_TEMP: max_temp_q <= signed'(cfg_wdata);
					default: ;
				endcase
			end
			if (do_insert) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q   <= req.data;
				rd_idx_q <= '0;
				found_q  <= 1'b0;
			end
			ST_SEARCH: begin
				if (hit) begin
					found_q <= 1'b1;
					room_q  <= hit_room;
				end else if (!last) begin
					rd_idx_q <= map_raddr;
				end
			end
			ST_WREAD: begin
				sum_q       <= win_sum;
				oldest_nz_q <= (win_shift[TEMP_W-1:0] != '0);
			end
			ST_MUL: begin
				sign_q <= sum_q[SUM_W-1];
				prod_q <= PROD_W'(abs_sum) * PROD_W'(RECIP);
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_data_q <= res;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(MAX_SENSORS))
		else $error("entry count beyond table size");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("event beat raised outside completion state");

	a_insert_reports_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_count_q != $past(entry_count_q)) |->
			(rsp_valid_q && rsp_data_q.event_code == EV_OK && item_q.mode == MODE_LOAD))
		else $error("table grew without an accepted load event");
`endif
endmodule

### tb/tb_sensor_running_average_monitor.sv
// ----------------------------------------------------------------------------
// tb_sensor_running_average_monitor
// Self-checking bench for the sensor running-average monitor. A directed
// table covers table loads, duplicates, unknown sensors, window fill, zero
// and truncated averages and both alarms. Random traffic in six segments
// of SEG_ITEMS beats follows, each under its own limit setting; the stall
// pattern changes every second segment. Every event beat is checked
// field by field against the directed row or the in-bench table model.
// ----------------------------------------------------------------------------
module tb_sensor_running_average_monitor;
	timeunit 1ns;
	timeprecision 1ps;

	import srma_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = MAX_SENSORS_DEF + 16;
	localparam int SEG_ITEMS     = 180;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	srma_stream_if #(.T(in_item_t))  req_if ();
	srma_stream_if #(.T(out_item_t)) rsp_if ();

	sensor_running_average_monitor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// sensor table model
	logic [ID_W-1:0]          map_id     [MAX_SENSORS_DEF];
	logic [ID_W-1:0]          map_room   [MAX_SENSORS_DEF];
	logic signed [TEMP_W-1:0] map_window [MAX_SENSORS_DEF][WINDOW_LEN_DEF];
	int                       map_count;
	logic signed [TEMP_W-1:0] min_limit;
	logic signed [TEMP_W-1:0] max_limit;

	out_item_t pending_events [$];
	dir_row_t  dir_rows [$];
	int        err_count;
	int        cycle_cnt;
	int        tx_idle;
	int        rx_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("sensor_running_average_monitor test failed");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH %s", $realtime, what);
		err_count++;
	endtask

	function automatic out_item_t predict_event(in_item_t it);
		out_item_t ev;
		int        hit;
		int        sum;
		int        mean;
		hit = -1;
		for (int i = 0; i < map_count; i++)
			if (hit < 0 && map_id[i] == it.sensor_tag)
				hit = i;
		ev = '0;
		ev.event_sensor = it.sensor_tag;
		if (it.mode == MODE_LOAD) begin
			if (hit >= 0) begin
				ev.event_code = EV_DUPLICATE;
				ev.event_room = map_room[hit];
			end else if (map_count >= MAX_SENSORS_DEF) begin
				ev.event_code = EV_FULL;
				ev.event_room = it.room_id;
			end else begin
				map_id[map_count]   = it.sensor_tag;
				map_room[map_count] = it.room_id;
				for (int k = 0; k < WINDOW_LEN_DEF; k++)
					map_window[map_count][k] = '0;
				map_count++;
				ev.event_code = EV_OK;
				ev.event_room = it.room_id;
			end
		end else begin
			ev.event_time = it.sample_time;
			if (hit < 0) begin
				ev.event_code = EV_UNKNOWN;
			end else begin
				ev.event_room = map_room[hit];
				for (int k = 0; k < WINDOW_LEN_DEF - 1; k++)
					map_window[hit][k] = map_window[hit][k+1];
				map_window[hit][WINDOW_LEN_DEF-1] = it.sample_value;
				mean = 0;
				// oldest slot still zero: window not filled yet
				if (map_window[hit][0] != 0) begin
					sum = 0;
					for (int k = 0; k < WINDOW_LEN_DEF; k++)
						sum += map_window[hit][k];
					mean = sum / WINDOW_LEN_DEF;
				end
				ev.average = mean[TEMP_W-1:0];
				if (mean != 0 && mean < min_limit)
					ev.event_code = EV_TOO_COLD;
				else if (mean != 0 && mean > max_limit)
					ev.event_code = EV_TOO_WARM;
				else
					ev.event_code = EV_OK;
			end
		end
		return ev;
	endfunction

	function automatic in_item_t mk_item(logic mode, logic [ID_W-1:0] sid, logic [ID_W-1:0] rid,
		logic signed [TEMP_W-1:0] val, logic [TIME_W-1:0] ts);
		in_item_t it;
		it.mode         = mode;
		it.sensor_tag   = sid;
		it.room_id      = rid;
		it.sample_value = val;
		it.sample_time  = ts;
		return it;
	endfunction

	function automatic out_item_t mk_event(logic [CODE_W-1:0] code, logic [ID_W-1:0] sid,
		logic [ID_W-1:0] room, logic signed [TEMP_W-1:0] avg, logic [TIME_W-1:0] ts);
		out_item_t ev;
		ev.event_code   = code;
		ev.event_sensor = sid;
		ev.event_room   = room;
		ev.average      = avg;
		ev.event_time   = ts;
		return ev;
	endfunction

	function automatic void add_row(in_item_t it, bit typed, out_item_t want);
		dir_row_t row;
		row.stim  = it;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int       pick;
		int       lo;
		int       hi;
		int       v;
		int       span;
		it.mode        = MODE_SAMPLE;
		it.sensor_tag  = ID_W'($urandom);
		it.room_id     = ID_W'($urandom);
		it.sample_time = $urandom;
		pick = $urandom_range(99);
		if (pick < 18) begin
			it.mode = MODE_LOAD;
			if (map_count > 0 && $urandom_range(99) < 30)
				it.sensor_tag = map_id[$urandom_range(map_count - 1)];
		end else if (pick < 90 && map_count > 0) begin
			// favor the most recently loaded sensors so windows wrap often
			if ($urandom_range(1) == 0) begin
				span = (map_count < 4) ? map_count - 1 : 3;
				it.sensor_tag = map_id[map_count - 1 - int'($urandom_range(span))];
			end else begin
				it.sensor_tag = map_id[$urandom_range(map_count - 1)];
			end
		end
		pick = $urandom_range(99);
		if (pick < 55) begin
			lo = int'(min_limit) - 1500;
			hi = int'(max_limit) + 1500;
			if (lo > hi) begin
				v  = lo;
				lo = hi;
				hi = v;
			end
			if (lo < -32768) lo = -32768;
			if (hi > 32767) hi = 32767;
			v = lo + int'($urandom_range(hi - lo));
			it.sample_value = v[TEMP_W-1:0];
		end else if (pick < 70) begin
			it.sample_value = TEMP_W'($urandom);
		end else if (pick < 80) begin
			it.sample_value = '0;
		end else if (pick < 90) begin
			it.sample_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		end else begin
			v = int'($urandom_range(16)) - 8;
			it.sample_value = v[TEMP_W-1:0];
		end
		return it;
	endfunction

	task automatic push_beat(in_item_t it, bit typed, out_item_t want);
		out_item_t ev;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.data  = it;
		do @(posedge clk); while (!req_if.ready);
		ev = predict_event(it);
		pending_events.push_back(typed ? want : ev);
	endtask

	task automatic drain();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = val;
		if (idx == REG_MIN_TEMP)
			min_limit = val;
		else if (idx == REG_MAX_TEMP)
			max_limit = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic check_event(out_item_t got);
		out_item_t want;
		if (pending_events.size() == 0) begin
			report_mismatch($sformatf("unexpected event beat sensor %0h", got.event_sensor));
		end else begin
			want = pending_events.pop_front();
			if (got.event_code !== want.event_code)
				report_mismatch($sformatf("sensor %0h code %0d, want %0d",
					want.event_sensor, got.event_code, want.event_code));
			if (got.event_sensor !== want.event_sensor)
				report_mismatch($sformatf("sensor %0h, want %0h",
					got.event_sensor, want.event_sensor));
			if (got.event_room !== want.event_room)
				report_mismatch($sformatf("sensor %0h room %0h, want %0h",
					want.event_sensor, got.event_room, want.event_room));
			if (got.average !== want.average)
				report_mismatch($sformatf("sensor %0h average %0d, want %0d",
					want.event_sensor, $signed(got.average), $signed(want.average)));
			if (got.event_time !== want.event_time)
				report_mismatch($sformatf("sensor %0h time %0h, want %0h",
					want.event_sensor, got.event_time, want.event_time));
		end
	endtask

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready = ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			check_event(rsp_if.data);
	end

	initial begin
		int lo;
		int hi;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_wdata    = '0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		tx_idle      = 0;
		rx_idle      = 0;
		err_count    = 0;
		cycle_cnt    = 0;
		map_count    = 0;
		min_limit    = MIN_TEMP_RST;
		max_limit    = MAX_TEMP_RST;

		// empty table, loads, duplicate, extreme windows, truncation and zero average
		add_row(mk_item(MODE_SAMPLE, 16'h1234, 16'hBEEF, 16'sh0100, 32'hFFFF_FFFF), 1,
			mk_event(EV_UNKNOWN, 16'h1234, 16'h0000, 16'sh0000, 32'hFFFF_FFFF));
		add_row(mk_item(MODE_LOAD, 16'h0000, 16'hFFFF, 16'sh7FFF, 32'hFFFF_FFFF), 1,
			mk_event(EV_OK, 16'h0000, 16'hFFFF, 16'sh0000, 32'h0));
		add_row(mk_item(MODE_LOAD, 16'hFFFF, 16'h0000, 16'sh8000, 32'h0), 1,
			mk_event(EV_OK, 16'hFFFF, 16'h0000, 16'sh0000, 32'h0));
		add_row(mk_item(MODE_LOAD, 16'h0000, 16'h1234, 16'sh0000, 32'hDEAD_BEEF), 1,
			mk_event(EV_DUPLICATE, 16'h0000, 16'hFFFF, 16'sh0000, 32'h0));
		for (int i = 1; i < WINDOW_LEN_DEF; i++)
			add_row(mk_item(MODE_SAMPLE, 16'hFFFF, 16'h0, 16'sh7FFF, i), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'hFFFF, 16'h0, 16'sh7FFF, 32'h5), 1,
			mk_event(EV_TOO_WARM, 16'hFFFF, 16'h0000, 16'sh7FFF, 32'h5));
		for (int i = 1; i < WINDOW_LEN_DEF; i++)
			add_row(mk_item(MODE_SAMPLE, 16'h0000, 16'h0, 16'sh8000, 32'h100 + i), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'h0000, 16'h0, 16'sh8000, 32'h8000_0000), 1,
			mk_event(EV_TOO_COLD, 16'h0000, 16'hFFFF, 16'sh8000, 32'h8000_0000));
		add_row(mk_item(MODE_LOAD, 16'h00AA, 16'h5A5A, 16'sh0, 32'h0), 1,
			mk_event(EV_OK, 16'h00AA, 16'h5A5A, 16'sh0000, 32'h0));
		add_row(mk_item(MODE_SAMPLE, 16'h00AA, 16'h0, 16'sh0000, 32'h200), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'h00AA, 16'h0, 16'sh0003, 32'h201), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'h00AA, 16'h0, 16'sh0003, 32'h202), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'h00AA, 16'h0, 16'sh0003, 32'h203), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'h00AA, 16'h0, -16'sd9, 32'h204), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'h00AA, 16'h0, 16'sh0000, 32'h205), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'h00AA, 16'h0, -16'sd1, 32'h206), 0, '0);
		add_row(mk_item(MODE_SAMPLE, 16'h00AA, 16'h0, -16'sd3, 32'h207), 0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			push_beat(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

		for (int seg = 0; seg < 6; seg++) begin
			drain();
			case (seg)
				0: begin
					write_reg(REG_MIN_TEMP, 16'h8000);
					write_reg(REG_MAX_TEMP, 16'h7FFF);
				end
				2: begin
					// crossed limits: cold takes priority
					write_reg(REG_MIN_TEMP, 16'h7FFF);
					write_reg(REG_MAX_TEMP, 16'h8000);
				end
				4: begin
					write_reg(REG_MIN_TEMP, 16'h0000);
					write_reg(REG_MAX_TEMP, 16'h0000);
				end
				default: begin
					lo = int'($urandom_range(12000)) - 6000;
					hi = lo + int'($urandom_range(6000));
					write_reg(REG_MIN_TEMP, lo[CFG_W-1:0]);
					write_reg(REG_MAX_TEMP, hi[CFG_W-1:0]);
					if (seg == 3) begin
						write_reg(REG_SPARE_A, CFG_W'($urandom));
						write_reg(REG_SPARE_B, CFG_W'($urandom));
					end
				end
			endcase
			if (seg < 2) begin
				tx_idle = 22;
				rx_idle = 49;
			end else if (seg < 4) begin
				tx_idle = 49;
				rx_idle = 22;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			repeat (SEG_ITEMS)
				push_beat(rand_item(), 0, '0);
		end
		drain();

		if (err_count == 0)
			$display("sensor_running_average_monitor test passed");
		else
			$display("sensor_running_average_monitor test failed");
		$finish;
	end

endmodule

### sim.f
sv/srma_pkg.sv
sv/srma_stream_if.sv
sv/srma_ram.sv
sv/sensor_running_average_monitor.sv
tb/tb_sensor_running_average_monitor.sv
